// File: rtl/core/sca_pkg.sv
// Shared constants, types and helpers of the slab size class allocator.
// No dependencies; used by every module of the allocator but sca_ram.
package sca_pkg;

  localparam int unsigned SLAB_BYTES   = 1024;
  localparam int unsigned MIN_OBJ      = 4;
  localparam int unsigned NUM_CLASSES  = 9;
  localparam int unsigned MAX_SLABS    = 64;
  localparam int unsigned SLOTS_MAX    = SLAB_BYTES / MIN_OBJ;
  localparam int unsigned NUM_SLOTS    = MAX_SLABS * SLOTS_MAX;

  localparam int unsigned SLAB_W   = $clog2(MAX_SLABS);
  localparam int unsigned INNER_W  = 9;
  localparam int unsigned OFFS_W   = $clog2(SLOTS_MAX);
  localparam int unsigned IDX_W    = $clog2(NUM_SLOTS);
  localparam int unsigned CLASS_W  = 4;
  localparam int unsigned BYTES_W  = 11;
  localparam int unsigned LEN_W    = IDX_W + 1;
  localparam int unsigned NSLAB_W  = SLAB_W + 1;
  localparam int unsigned CSEL_W   = $clog2(NUM_CLASSES);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_SLAB   = 2'd2,
    STATUS_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  // One word per slot: in-use flag and free list link.
  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] link;
  } slot_word_t;

  // One word per slab: its class and the bytes handed out from it.
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [BYTES_W-1:0] bytes;
  } slab_word_t;

  function automatic logic [BYTES_W-1:0] slot_bytes(input logic [CLASS_W-1:0] cls);
    slot_bytes = BYTES_W'(MIN_OBJ) << cls;
  endfunction

  function automatic logic [INNER_W-1:0] slots_in_slab(input logic [CLASS_W-1:0] cls);
    slots_in_slab = INNER_W'(SLOTS_MAX) >> cls;
  endfunction

endpackage

// File: rtl/core/sca_ram.sv
// Simple dual-port synchronous RAM with registered read.
// Depends on nothing; instantiated by the allocator top level.
module sca_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/core/slab_size_class_allocator.sv
// Slab size class allocator: top level with sequencer, free lists and result register.
// Depends on sca_pkg and sca_ram.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one request per
// transaction: mode_i 0 allocates a slot for request_size_i payload bytes,
// mode_i 1 frees slot free_inner_i of slab free_slab_i. The output channel
// (out_valid_o / out_stall_i) returns exactly one result per request.
// A request passes a read state, in which the slot word and the slab word are
// fetched from their memories, and an execute state, in which they are
// modified and written back. The result is registered at the end of the
// execute state; the block takes no new request until then, as the
// read-modify-write pass over the slot memory must finish first.
// The result sits in an output register; a new request may be accepted while
// it waits, but the execute state holds until the receiver takes the old one.
// Reset empties all free lists and slab counters at once; no clearing pass is
// needed, as slot flags are only trusted for slots already handed out.
module slab_size_class_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [15:0]                  request_size_i,
  input  logic [sca_pkg::SLAB_W-1:0]   free_slab_i,
  input  logic [sca_pkg::INNER_W-1:0]  free_inner_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [sca_pkg::SLAB_W-1:0]   slab_id_o,
  output logic [sca_pkg::INNER_W-1:0]  inner_id_o,
  output logic [2:0]                   header_bytes_o,
  output logic [sca_pkg::CLASS_W-1:0]  size_class_o,
  output logic [sca_pkg::BYTES_W-1:0]  slab_bytes_used_o
);

  localparam int unsigned NC    = sca_pkg::NUM_CLASSES;
  localparam int unsigned SW    = sca_pkg::SLAB_W;
  localparam int unsigned IW    = sca_pkg::INNER_W;
  localparam int unsigned OW    = sca_pkg::OFFS_W;
  localparam int unsigned XW    = sca_pkg::IDX_W;
  localparam int unsigned CW    = sca_pkg::CLASS_W;
  localparam int unsigned BW    = sca_pkg::BYTES_W;
  localparam int unsigned LW    = sca_pkg::LEN_W;
  localparam int unsigned NSW   = sca_pkg::NSLAB_W;
  localparam int unsigned CSW   = sca_pkg::CSEL_W;

  sca_pkg::state_e state_q, state_d;

  logic          mode_q;
  logic [15:0]   size_q;
  logic [SW-1:0] fslab_q;
  logic [IW-1:0] finner_q;

  logic [XW-1:0]  head_q       [NC];
  logic [LW-1:0]  len_q        [NC];
  logic [SW-1:0]  fresh_slab_q [NC];
  logic [IW-1:0]  fresh_left_q [NC];
  logic [NSW-1:0] next_slab_q;

  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [SW-1:0] slab_q;
  logic [IW-1:0] inner_q;
  logic [2:0]    hdr_q;
  logic [CW-1:0] cls_q;
  logic [BW-1:0] bytes_q;

  logic accept, exec_fire;

  // Allocation class decode.
  logic [2:0]    a_hdr;
  logic [16:0]   a_total;
  logic          a_found;
  logic [CSW-1:0] a_cls;

  // Memory ports.
  logic [XW-1:0]        slot_raddr, slot_waddr;
  logic [SW-1:0]        slab_raddr, slab_waddr;
  sca_pkg::slot_word_t  slot_rd, slot_wd;
  sca_pkg::slab_word_t  slab_rd, slab_wd;
  logic                 slot_we, slab_we;

  // Execute results.
  sca_pkg::status_e res_status;
  logic [SW-1:0]    res_slab;
  logic [IW-1:0]    res_inner;
  logic [2:0]       res_hdr;
  logic [CW-1:0]    res_cls;
  logic [BW-1:0]    res_bytes;
  logic             do_pop, do_push, do_open, do_take;
  logic [CSW-1:0]   u_cls;
  logic [XW-1:0]    u_idx;

  // Free decode.
  logic [CSW-1:0] f_cls;
  logic           f_cls_ok, f_slab_ok, f_inner_ok, f_untouched, f_used;
  logic [IW-1:0]  f_slots;
  logic [IW-1:0]  f_inner_m1;
  logic [IW-1:0]  a_slots;

  assign accept    = in_valid_i && !in_stall_o;
  assign exec_fire = (state_q == sca_pkg::ST_EXEC) && !(out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sca_pkg::ST_IDLE: if (accept)    state_d = sca_pkg::ST_READ;
      sca_pkg::ST_READ:                state_d = sca_pkg::ST_EXEC;
      sca_pkg::ST_EXEC: if (exec_fire) state_d = sca_pkg::ST_IDLE;
      default:                         state_d = sca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != sca_pkg::ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sca_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      size_q   <= request_size_i;
      fslab_q  <= free_slab_i;
      finner_q <= free_inner_i;
    end
  end

  // Smallest class whose slot holds payload plus header.
  always_comb begin
    a_hdr   = (size_q <= 16'd255) ? 3'd1 : 3'd2;
    a_total = {1'b0, size_q} + 17'(a_hdr);
    a_found = 1'b0;
    a_cls   = '0;
    for (int c = 0; c < NC; c++) begin
      if (!a_found && a_total <= (17'(sca_pkg::MIN_OBJ) << c) &&
          (sca_pkg::MIN_OBJ << c) <= sca_pkg::SLAB_BYTES) begin
        a_found = 1'b1;
        a_cls   = CSW'(c);
      end
    end
  end

  // Read addresses follow only held registers, so they stay put while execute waits.
  always_comb begin
    if (mode_q) begin
      slot_raddr = {fslab_q, OW'(finner_q - IW'(1))};
      slab_raddr = fslab_q;
    end else begin
      slot_raddr = head_q[a_cls];
      slab_raddr = (len_q[a_cls] != '0) ? head_q[a_cls][XW-1:OW] : fresh_slab_q[a_cls];
    end
  end

  sca_ram #(.Depth(sca_pkg::NUM_SLOTS), .Width($bits(sca_pkg::slot_word_t))) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wd),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rd)
  );

  sca_ram #(.Depth(sca_pkg::MAX_SLABS), .Width($bits(sca_pkg::slab_word_t))) u_slab_ram (
    .clk_i   (clk_i),
    .we_i    (slab_we),
    .waddr_i (slab_waddr),
    .wdata_i (slab_wd),
    .raddr_i (slab_raddr),
    .rdata_o (slab_rd)
  );

  // Free checks. A slot of the class's current fresh slab whose id has not yet
  // been handed out was never written, so its flag is not trusted.
  always_comb begin
    f_cls_ok    = (slab_rd.cls < CW'(NC));
    f_cls       = f_cls_ok ? CSW'(slab_rd.cls) : '0;
    f_slab_ok   = ({1'b0, fslab_q} < next_slab_q);
    f_slots     = sca_pkg::slots_in_slab(slab_rd.cls);
    f_inner_ok  = (finner_q != '0) && (finner_q <= f_slots);
    f_inner_m1  = finner_q - IW'(1);
    f_untouched = (fslab_q == fresh_slab_q[f_cls]) && (finner_q <= fresh_left_q[f_cls]);
    f_used      = !f_untouched && slot_rd.used;
    a_slots     = sca_pkg::slots_in_slab(CW'(a_cls));
  end

  always_comb begin
    res_status = sca_pkg::STATUS_OK;
    res_slab   = '0;
    res_inner  = '0;
    res_hdr    = '0;
    res_cls    = '0;
    res_bytes  = '0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    do_open    = 1'b0;
    do_take    = 1'b0;
    u_cls      = '0;
    u_idx      = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wd    = '0;
    slab_we    = 1'b0;
    slab_waddr = '0;
    slab_wd    = '0;

    if (mode_q) begin
      if (!f_slab_ok || !f_cls_ok || !f_inner_ok || !f_used) begin
        res_status = sca_pkg::STATUS_BAD_FREE;
      end else begin
        u_cls         = f_cls;
        u_idx         = {fslab_q, f_inner_m1[OW-1:0]};
        do_push       = 1'b1;
        res_slab      = fslab_q;
        res_inner     = finner_q;
        res_cls       = CW'(f_cls);
        res_bytes     = slab_rd.bytes - sca_pkg::slot_bytes(CW'(f_cls));
        slot_we       = exec_fire;
        slot_waddr    = u_idx;
        slot_wd.used  = 1'b0;
        slot_wd.link  = head_q[f_cls];
        slab_we       = exec_fire;
        slab_waddr    = fslab_q;
        slab_wd.cls   = slab_rd.cls;
        slab_wd.bytes = res_bytes;
      end
    end else if (!a_found) begin
      res_status = sca_pkg::STATUS_TOO_LARGE;
    end else begin
      u_cls   = a_cls;
      res_hdr = a_hdr;
      res_cls = CW'(a_cls);
      if (len_q[a_cls] != '0) begin
        do_pop    = 1'b1;
        u_idx     = head_q[a_cls];
        res_slab  = head_q[a_cls][XW-1:OW];
        res_inner = IW'(head_q[a_cls][OW-1:0]) + IW'(1);
        res_bytes = slab_rd.bytes + sca_pkg::slot_bytes(CW'(a_cls));
      end else if (fresh_left_q[a_cls] == '0) begin
        if (next_slab_q >= NSW'(sca_pkg::MAX_SLABS)) begin
          res_status = sca_pkg::STATUS_NO_SLAB;
          res_hdr    = '0;
          res_cls    = '0;
        end else begin
          do_open   = 1'b1;
          res_slab  = next_slab_q[SW-1:0];
          res_inner = a_slots;
          res_bytes = sca_pkg::slot_bytes(CW'(a_cls));
        end
      end else begin
        do_take   = 1'b1;
        res_slab  = fresh_slab_q[a_cls];
        res_inner = fresh_left_q[a_cls];
        res_bytes = slab_rd.bytes + sca_pkg::slot_bytes(CW'(a_cls));
      end
      if (res_status == sca_pkg::STATUS_OK) begin
        u_idx         = {res_slab, OW'(res_inner - IW'(1))};
        slot_we       = exec_fire;
        slot_waddr    = u_idx;
        slot_wd.used  = 1'b1;
        slot_wd.link  = '0;
        slab_we       = exec_fire;
        slab_waddr    = res_slab;
        slab_wd.cls   = CW'(a_cls);
        slab_wd.bytes = res_bytes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NC; c++) begin
        head_q[c]       <= '0;
        len_q[c]        <= '0;
        fresh_slab_q[c] <= '0;
        fresh_left_q[c] <= '0;
      end
      next_slab_q <= '0;
    end else if (exec_fire) begin
      if (do_pop) begin
        head_q[u_cls] <= slot_rd.link;
        len_q[u_cls]  <= len_q[u_cls] - LW'(1);
      end
      if (do_push) begin
        head_q[u_cls] <= u_idx;
        len_q[u_cls]  <= len_q[u_cls] + LW'(1);
      end
      if (do_open) begin
        fresh_slab_q[u_cls] <= next_slab_q[SW-1:0];
        fresh_left_q[u_cls] <= a_slots - IW'(1);
        next_slab_q         <= next_slab_q + NSW'(1);
      end
      if (do_take) begin
        fresh_left_q[u_cls] <= fresh_left_q[u_cls] - IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      status_q <= res_status;
      slab_q   <= res_slab;
      inner_q  <= res_inner;
      hdr_q    <= res_hdr;
      cls_q    <= res_cls;
      bytes_q  <= res_bytes;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign slab_id_o         = slab_q;
  assign inner_id_o        = inner_q;
  assign header_bytes_o    = hdr_q;
  assign size_class_o      = cls_q;
  assign slab_bytes_used_o = bytes_q;

endmodule

// File: rtl/core/sca_checker.sv
// Port-level checker for the slab size class allocator, bound to the top level.
// Depends on sca_pkg and slab_size_class_allocator.
module sca_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [1:0]                   status_o,
  input logic [sca_pkg::INNER_W-1:0]  inner_id_o,
  input logic [2:0]                   header_bytes_o,
  input logic [sca_pkg::BYTES_W-1:0]  slab_bytes_used_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(inner_id_o) && $stable(slab_bytes_used_o))
    else $error("stalled result changed");

  // One transaction at a time: the input stalls right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // Errors carry no slot, header or byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sca_pkg::STATUS_OK |->
      inner_id_o == '0 && header_bytes_o == '0 && slab_bytes_used_o == '0)
    else $error("error result with nonzero fields");

  // A successful transaction always names a slot and leaves bytes in use on allocate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sca_pkg::STATUS_OK |->
      inner_id_o != '0 && (header_bytes_o == '0 || slab_bytes_used_o != '0))
    else $error("successful result without slot");

endmodule

bind slab_size_class_allocator sca_checker u_sca_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .inner_id_o        (inner_id_o),
  .header_bytes_o    (header_bytes_o),
  .slab_bytes_used_o (slab_bytes_used_o)
);

// File: dv/tb_top.sv
// Self-checking testbench of the slab size class allocator: directed and random
// allocate/free transactions, checked against an in-bench allocator predictor.
// Depends on sca_pkg and slab_size_class_allocator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sca_pkg::status_e status;
    logic [5:0]       slab;
    logic [8:0]       inner;
    logic [2:0]       hdr;
    logic [3:0]       cls;
    logic [10:0]      used;
  } alloc_res_t;

  class alloc_scoreboard;
    int unsigned head [sca_pkg::NUM_CLASSES];
    int unsigned list_len [sca_pkg::NUM_CLASSES];
    int unsigned link [sca_pkg::NUM_SLOTS];
    int unsigned fresh_slab [sca_pkg::NUM_CLASSES];
    int unsigned fresh_left [sca_pkg::NUM_CLASSES];
    int unsigned next_slab;
    int unsigned slab_cls [sca_pkg::MAX_SLABS];
    bit          in_use [sca_pkg::NUM_SLOTS];
    int unsigned slab_used [sca_pkg::MAX_SLABS];
    alloc_res_t  pending [$];
    int unsigned errors;

    function void note_request(bit mode, int unsigned size, int unsigned fslab,
                               int unsigned finner);
      alloc_res_t r;
      int unsigned hdr, total, c, s, n, idx;
      r = '0;
      r.status = sca_pkg::STATUS_OK;
      if (mode == 1'b0) begin
        hdr = (size <= 255) ? 1 : 2;
        total = size + hdr;
        c = 0;
        while (c < sca_pkg::NUM_CLASSES && total > (sca_pkg::MIN_OBJ << c)) c++;
        if (c >= sca_pkg::NUM_CLASSES || (sca_pkg::MIN_OBJ << c) > sca_pkg::SLAB_BYTES) begin
          r.status = sca_pkg::STATUS_TOO_LARGE;
        end else if (list_len[c] > 0) begin
          idx = head[c];
          head[c] = link[idx];
          list_len[c]--;
          s = idx / sca_pkg::SLOTS_MAX;
          n = idx % sca_pkg::SLOTS_MAX + 1;
        end else if (fresh_left[c] == 0 && next_slab >= sca_pkg::MAX_SLABS) begin
          r.status = sca_pkg::STATUS_NO_SLAB;
        end else begin
          if (fresh_left[c] == 0) begin
            fresh_slab[c] = next_slab;
            fresh_left[c] = sca_pkg::SLAB_BYTES / (sca_pkg::MIN_OBJ << c);
            slab_cls[next_slab] = c;
            slab_used[next_slab] = 0;
            next_slab++;
          end
          s = fresh_slab[c];
          n = fresh_left[c];
          fresh_left[c]--;
          idx = s * sca_pkg::SLOTS_MAX + n - 1;
        end
        if (r.status == sca_pkg::STATUS_OK) begin
          in_use[idx] = 1'b1;
          slab_used[s] += sca_pkg::MIN_OBJ << c;
          r.slab = s; r.inner = n; r.hdr = hdr; r.cls = c; r.used = slab_used[s];
        end
      end else begin
        r.status = sca_pkg::STATUS_BAD_FREE;
        if (fslab < next_slab) begin
          c = slab_cls[fslab];
          idx = fslab * sca_pkg::SLOTS_MAX + finner - 1;
          if (finner != 0 && finner <= sca_pkg::SLAB_BYTES / (sca_pkg::MIN_OBJ << c) &&
              in_use[idx]) begin
            in_use[idx] = 1'b0;
            slab_used[fslab] -= sca_pkg::MIN_OBJ << c;
            link[idx] = head[c];
            head[c] = idx;
            list_len[c]++;
            r.status = sca_pkg::STATUS_OK;
            r.slab = fslab; r.inner = finner; r.cls = c; r.used = slab_used[fslab];
          end
        end
      end
      pending = {pending, r};
    endfunction

    function void check_result(alloc_res_t act);
      alloc_res_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (exp.status != act.status) report("status", exp.status, act.status);
      if (exp.slab != act.slab) report("slab_id", exp.slab, act.slab);
      if (exp.inner != act.inner) report("inner_id", exp.inner, act.inner);
      if (exp.hdr != act.hdr) report("header_bytes", exp.hdr, act.hdr);
      if (exp.cls != act.cls) report("size_class", exp.cls, act.cls);
      if (exp.used != act.used) report("slab_bytes_used", exp.used, act.used);
    endfunction

    function void report(string field, int unsigned e, int unsigned a);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, e, a);
      errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = 1'b0;
  logic [15:0] request_size_i = '0;
  logic [sca_pkg::SLAB_W-1:0] free_slab_i = '0;
  logic [sca_pkg::INNER_W-1:0] free_inner_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [sca_pkg::SLAB_W-1:0] slab_id_o;
  logic [sca_pkg::INNER_W-1:0] inner_id_o;
  logic [2:0] header_bytes_o;
  logic [sca_pkg::CLASS_W-1:0] size_class_o;
  logic [sca_pkg::BYTES_W-1:0] slab_bytes_used_o;

  alloc_scoreboard book = new();
  int unsigned send_idle_pct, stall_pct;
  int unsigned cycles;
  // Slots handed out and still live, so that most frees hit real slots.
  int unsigned live_slab [$];
  int unsigned live_inner [$];
  // Sizes at the header and class boundaries.
  int unsigned dir_sizes [10] = '{0, 2, 3, 254, 255, 256, 1021, 1022, 1023, 65535};

  always #4 clk_i = ~clk_i;

  slab_size_class_allocator dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (out_valid_o && !out_stall_i) begin
      book.check_result({sca_pkg::status_e'(status_o), slab_id_o, inner_id_o,
                         header_bytes_o, size_class_o, slab_bytes_used_o});
      if (status_o == sca_pkg::STATUS_OK && header_bytes_o != 0) begin
        live_slab = {live_slab, int'(slab_id_o)};
        live_inner = {live_inner, int'(inner_id_o)};
      end
    end
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The valid line stays high after the last accepted transaction; idling and
  // drain() take it low, so it is written only once per time step.
  task automatic send(bit mode, int unsigned size, int unsigned fslab, int unsigned finner);
    logic [15:0]                 sz_v;
    logic [sca_pkg::SLAB_W-1:0]  sl_v;
    logic [sca_pkg::INNER_W-1:0] in_v;
    sz_v = 16'(size);
    sl_v = sca_pkg::SLAB_W'(fslab);
    in_v = sca_pkg::INNER_W'(finner);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    request_size_i <= sz_v;
    free_slab_i <= sl_v;
    free_inner_i <= in_v;
    do @(posedge clk_i); while (in_stall_o);
    book.note_request(mode, sz_v, sl_v, in_v);
  endtask

  task automatic send_alloc();
    int unsigned sz;
    case ($urandom_range(9))
      0: sz = $urandom_range(65535);
      1: sz = $urandom_range(1023, 256);
      default: sz = $urandom_range(255);
    endcase
    send(1'b0, sz, $urandom, $urandom);
  endtask

  task automatic send_free();
    int unsigned k;
    if (live_slab.size() > 0 && $urandom_range(9) < 8) begin
      k = $urandom_range(live_slab.size() - 1);
      send(1'b1, $urandom, live_slab[k], live_inner[k]);
      live_slab.delete(k);
      live_inner.delete(k);
    end else begin
      send(1'b1, $urandom, $urandom_range(63), $urandom_range(511));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Extremes of size and header, the largest class, oversize and bad frees.
    send(1'b1, 0, 0, 1);
    foreach (dir_sizes[i])
      send(1'b0, dir_sizes[i], 0, 0);
    send(1'b1, 16'hFFFF, 0, 0);
    send(1'b1, 0, 0, 256);
    send(1'b1, 0, 0, 1);
    send(1'b1, 0, 0, 1);
    send(1'b1, 0, 63, 511);
    send(1'b0, 3, 63, 0);
    send(1'b0, 3, 0, 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 45) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 45) : 0;
      for (int i = 0; i < 260; i++) begin
        if ($urandom_range(99) < 55) send_alloc();
        else send_free();
      end
      // Hold off until the block has nothing left in flight.
      drain();
    end
    repeat (20) @(posedge clk_i);
    if (book.errors == 0 && book.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/sca_pkg.sv
rtl/core/sca_ram.sv
rtl/core/slab_size_class_allocator.sv
rtl/core/sca_checker.sv
dv/tb_top.sv
